/* design/tfd_pkg.sv */
// Package for the terminal receive FIFO device: item codes, telnet bytes,
// mode bit positions, FIFO sizing and the result record passed between stages.
// Depends on nothing.
`default_nettype none

package tfd_pkg;

   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CAP   = ((FIFO_DEPTH - 1) > 255) ? 255 : (FIFO_DEPTH - 1);

   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_BUS  = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [3:0] XFER_POP    = 4'd0;
   localparam logic [3:0] XFER_TX     = 4'd1;
   localparam logic [3:0] XFER_MODE   = 4'd3;
   localparam logic [3:0] XFER_STATUS = 4'd14;

   localparam logic [1:0] CTL_START = 2'd1;
   localparam logic [1:0] CTL_STOP  = 2'd2;

   localparam logic [7:0] BYTE_IAC     = 8'hFF;
   localparam logic [7:0] BYTE_SB      = 8'hFA;
   localparam logic [7:0] BYTE_SE      = 8'hF0;
   localparam logic [7:0] BYTE_CMD_LOW = 8'd250;
   localparam logic [7:0] BYTE_ESC     = 8'h1B;
   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_TAB     = 8'h09;
   localparam logic [7:0] BYTE_BELL    = 8'h07;

   localparam logic [8:0] READ_EMPTY = 9'h1FF;

   localparam int MODE_ENABLED  = 0;
   localparam int MODE_INTR_ANY = 1;
   localparam int MODE_INTR_ESC = 2;
   localparam int MODE_INTR_RET = 3;
   localparam int MODE_ECHO_RET = 6;
   localparam int MODE_ECHO_TAB = 7;
   localparam int MODE_ECHO_ALL = 8;

   localparam logic [15:0] MODE_RESET = 16'd456;

   typedef struct packed {
      logic       line_valid;
      logic [7:0] line_byte;
      logic [8:0] read_data;
      logic       pop;
      logic       irq;
   } tfd_result_type;

endpackage

`default_nettype wire

/* design/telnet_terminal_receive_fifo_device_top.sv */
// Telnet terminal receive FIFO device, top level; depends on tfd_pkg, tfd_ram, tfd_ctrl, tfd_out.
// An accepted item's result passes the wait stage, which holds it for the store's registered
// read, and then the output register; one item per cycle is accepted except while the input
// stalls, which happens only while both result stages are full and the result is stalled.
// Reset is synchronous and clears filter, pointers, count, mode, transmit and irq state;
// the receive store is not cleared, since no entry is read before it is written.
`default_nettype none

module telnet_terminal_receive_fifo_device_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_line_byte,
   input  wire logic [3:0]  req_transfer_code,
   input  wire logic [1:0]  req_control_code,
   input  wire logic [23:0] req_bus_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_line_out_valid,
   output logic [7:0]       rsp_line_out_byte,
   output logic signed [8:0] rsp_read_data,
   output logic             rsp_irq_level
);

   import tfd_pkg::*;

   logic             accept;
   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic             ram_rd_en;
   logic [PTR_W-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;
   tfd_result_type   result;

   assign accept = req_valid && !req_stall;

   tfd_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_rx_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   tfd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .line_byte    (req_line_byte),
      .transfer_code(req_transfer_code),
      .control_code (req_control_code),
      .bus_data     (req_bus_data),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .result       (result)
   );

   tfd_out u_out (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .result            (result),
      .ram_rd_data       (ram_rd_data),
      .rsp_stall         (rsp_stall),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_line_out_valid(rsp_line_out_valid),
      .rsp_line_out_byte (rsp_line_out_byte),
      .rsp_read_data     (rsp_read_data),
      .rsp_irq_level     (rsp_irq_level)
   );

endmodule

`default_nettype wire

/* design/tfd_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/tfd_ctrl.sv */
// Control core: telnet filter, FIFO pointers and count, mode, transmit and irq state.
// Drives the receive store ports and builds the result record of each item.
// Depends on tfd_pkg.
`default_nettype none

module tfd_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [1:0]                  kind,
   input  wire logic [7:0]                  line_byte,
   input  wire logic [3:0]                  transfer_code,
   input  wire logic [1:0]                  control_code,
   input  wire logic [23:0]                 bus_data,
   output logic                             ram_wr_en,
   output logic [tfd_pkg::PTR_W-1:0]        ram_wr_addr,
   output logic [7:0]                       ram_wr_data,
   output logic                             ram_rd_en,
   output logic [tfd_pkg::PTR_W-1:0]        ram_rd_addr,
   output tfd_pkg::tfd_result_type          result
);

   import tfd_pkg::*;

   typedef enum logic [1:0] {
      FS_NORMAL  = 2'd0,
      FS_COMMAND = 2'd1,
      FS_SUBNEG  = 2'd2
   } filter_state_type;

   filter_state_type   filter_state_ff, filter_state_in;
   logic [PTR_W-1:0]   read_pointer_ff, read_pointer_in;
   logic [PTR_W-1:0]   write_pointer_ff, write_pointer_in;
   logic [7:0]         fill_count_ff, fill_count_in;
   logic [15:0]        mode_bits_ff, mode_bits_in;
   logic [7:0]         fill_threshold_ff, fill_threshold_in;
   logic [7:0]         tx_byte_ff, tx_byte_in;
   logic               tx_pending_ff, tx_pending_in;
   logic               done_flag_ff, done_flag_in;
   logic               push_req;
   logic               echo;
   logic [7:0]         count_next;

   function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      filter_state_in   = filter_state_ff;
      read_pointer_in   = read_pointer_ff;
      write_pointer_in  = write_pointer_ff;
      fill_count_in     = fill_count_ff;
      mode_bits_in      = mode_bits_ff;
      fill_threshold_in = fill_threshold_ff;
      tx_byte_in        = tx_byte_ff;
      tx_pending_in     = tx_pending_ff;
      done_flag_in      = done_flag_ff;
      push_req          = 1'b0;
      echo              = 1'b0;
      count_next        = fill_count_ff + 8'd1;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = write_pointer_ff;
      ram_wr_data       = line_byte;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = read_pointer_ff;
      result            = '0;

      if (accept) begin
         unique case (kind)
            KIND_LINE: begin
               unique case (filter_state_ff)
                  FS_COMMAND: begin
                     if (line_byte == BYTE_IAC) begin
                        push_req        = 1'b1;
                        filter_state_in = FS_NORMAL;
                     end else if (line_byte == BYTE_SB) begin
                        filter_state_in = FS_SUBNEG;
                     end else if (line_byte < BYTE_CMD_LOW) begin
                        filter_state_in = FS_NORMAL;
                     end
                  end
                  FS_SUBNEG: begin
                     if (line_byte == BYTE_SE) begin
                        filter_state_in = FS_NORMAL;
                     end
                  end
                  default: begin
                     if (line_byte == BYTE_IAC) begin
                        filter_state_in = FS_COMMAND;
                     end else begin
                        filter_state_in = FS_NORMAL;
                        push_req        = 1'b1;
                     end
                  end
               endcase
            end
            KIND_BUS: begin
               if (transfer_code == XFER_TX) begin
                  tx_byte_in = bus_data[7:0];
               end else if (transfer_code == XFER_MODE) begin
                  mode_bits_in      = bus_data[23:8];
                  fill_threshold_in = bus_data[7:0];
               end
               if (transfer_code != XFER_STATUS) begin
                  if (control_code == CTL_START) begin
                     tx_pending_in = 1'b1;
                     done_flag_in  = 1'b0;
                  end else if (control_code == CTL_STOP) begin
                     tx_pending_in = 1'b0;
                     done_flag_in  = 1'b0;
                  end
               end
               if (transfer_code == XFER_STATUS) begin
                  result.read_data = {7'd0, done_flag_ff, tx_pending_ff};
               end else if (transfer_code == XFER_POP) begin
                  if (fill_count_ff == 8'd0) begin
                     result.read_data = READ_EMPTY;
                  end else begin
                     ram_rd_en       = 1'b1;
                     result.pop      = 1'b1;
                     read_pointer_in = next_index(read_pointer_ff);
                     fill_count_in   = fill_count_ff - 8'd1;
                  end
               end
            end
            KIND_TICK: begin
               if (tx_pending_ff) begin
                  result.line_valid = 1'b1;
                  result.line_byte  = tx_byte_ff;
                  tx_pending_in     = 1'b0;
               end
            end
            default: begin
            end
         endcase

         if (push_req) begin
            if ((fill_count_ff < 8'(FIFO_CAP)) && mode_bits_ff[MODE_ENABLED]) begin
               ram_wr_en        = 1'b1;
               write_pointer_in = next_index(write_pointer_ff);
               fill_count_in    = count_next;
               echo = mode_bits_ff[MODE_ECHO_ALL]
                  || (mode_bits_ff[MODE_ECHO_TAB] && (line_byte == BYTE_TAB))
                  || (mode_bits_ff[MODE_ECHO_RET]
                      && ((line_byte == BYTE_LF) || (line_byte == BYTE_CR)));
               if (mode_bits_ff[MODE_INTR_ANY]
                   || (mode_bits_ff[MODE_INTR_ESC] && (line_byte == BYTE_ESC))
                   || (mode_bits_ff[MODE_INTR_RET] && (line_byte == BYTE_LF))
                   || ((fill_threshold_ff != 8'd0) && (count_next >= fill_threshold_ff)))
               begin
                  done_flag_in = 1'b1;
               end
               if (echo) begin
                  result.line_valid = 1'b1;
                  result.line_byte  = line_byte;
               end
            end else begin
               result.line_valid = 1'b1;
               result.line_byte  = BYTE_BELL;
            end
         end
      end

      result.irq = done_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_state_ff   <= FS_NORMAL;
         read_pointer_ff   <= '0;
         write_pointer_ff  <= '0;
         fill_count_ff     <= 8'd0;
         mode_bits_ff      <= MODE_RESET;
         fill_threshold_ff <= 8'd0;
         tx_byte_ff        <= 8'd0;
         tx_pending_ff     <= 1'b0;
         done_flag_ff      <= 1'b0;
      end else begin
         filter_state_ff   <= filter_state_in;
         read_pointer_ff   <= read_pointer_in;
         write_pointer_ff  <= write_pointer_in;
         fill_count_ff     <= fill_count_in;
         mode_bits_ff      <= mode_bits_in;
         fill_threshold_ff <= fill_threshold_in;
         tx_byte_ff        <= tx_byte_in;
         tx_pending_ff     <= tx_pending_in;
         done_flag_ff      <= done_flag_in;
      end
   end

endmodule

`default_nettype wire

/* design/tfd_out.sv */
// Result pipeline: a stage that waits for the store read data, then the output register.
// Merges popped bytes into the result and produces the input stall.
// Depends on tfd_pkg.
`default_nettype none

module tfd_out (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire tfd_pkg::tfd_result_type result,
   input  wire logic [7:0]              ram_rd_data,
   input  wire logic                    rsp_stall,
   output logic                         req_stall,
   output logic                         rsp_valid,
   output logic                         rsp_line_out_valid,
   output logic [7:0]                   rsp_line_out_byte,
   output logic signed [8:0]            rsp_read_data,
   output logic                         rsp_irq_level
);

   import tfd_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   tfd_result_type s1_ff, s1_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_line_valid_ff, out_line_valid_in;
   logic [7:0]     out_line_byte_ff, out_line_byte_in;
   logic [8:0]     out_read_data_ff, out_read_data_in;
   logic           out_irq_ff, out_irq_in;
   logic           advance;

   always_comb begin
      advance           = s1_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall         = s1_valid_ff && out_valid_ff && rsp_stall;
      s1_valid_in       = s1_valid_ff;
      s1_in             = s1_ff;
      out_valid_in      = out_valid_ff;
      out_line_valid_in = out_line_valid_ff;
      out_line_byte_in  = out_line_byte_ff;
      out_read_data_in  = out_read_data_ff;
      out_irq_in        = out_irq_ff;

      if (advance) begin
         out_valid_in      = 1'b1;
         out_line_valid_in = s1_ff.line_valid;
         out_line_byte_in  = s1_ff.line_byte;
         out_read_data_in  = s1_ff.pop ? {1'b0, ram_rd_data} : s1_ff.read_data;
         out_irq_in        = s1_ff.irq;
         s1_valid_in       = 1'b0;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (accept) begin
         s1_valid_in = 1'b1;
         s1_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff             <= s1_in;
      out_line_valid_ff <= out_line_valid_in;
      out_line_byte_ff  <= out_line_byte_in;
      out_read_data_ff  <= out_read_data_in;
      out_irq_ff        <= out_irq_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_line_out_valid = out_line_valid_ff;
   assign rsp_line_out_byte  = out_line_byte_ff;
   assign rsp_read_data      = $signed(out_read_data_ff);
   assign rsp_irq_level      = out_irq_ff;

endmodule

`default_nettype wire

/* sim/tfd_result_monitor.sv */
`timescale 1ns / 100ps
// Result monitor for the telnet terminal receive FIFO device. It follows both channels,
// predicts every result from the accepted items and compares it field by field.
// Depends on tfd_pkg.
module tfd_result_monitor (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [7:0]         req_line_byte,
   input  wire logic [3:0]         req_transfer_code,
   input  wire logic [1:0]         req_control_code,
   input  wire logic [23:0]        req_bus_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               rsp_line_out_valid,
   input  wire logic [7:0]         rsp_line_out_byte,
   input  wire logic signed [8:0]  rsp_read_data,
   input  wire logic               rsp_irq_level,
   output int                      fail_count,
   output int                      pending_count
);

   import tfd_pkg::*;

   typedef enum logic [1:0] {
      FILT_DATA   = 2'd0,
      FILT_CMD    = 2'd1,
      FILT_SUBNEG = 2'd2
   } filt_state_type;

   typedef struct packed {
      logic       line_valid;
      logic [7:0] line_byte;
      logic [8:0] read_data;
      logic       irq;
   } term_out_type;

   filt_state_type filt_q;
   logic [7:0]  rx_mem [FIFO_DEPTH];
   int          rd_idx;
   int          wr_idx;
   int          fill_cnt;
   logic [15:0] mode_q;
   logic [7:0]  thresh_q;
   logic [7:0]  tx_q;
   logic        tx_pend_q;
   logic        done_q;
   term_out_type term_out_q [$];

   function automatic int next_slot(input int p);
      return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
   endfunction

   task automatic push_rx(input logic [7:0] ch, output logic lv, output logic [7:0] lb);
      logic echo;
      lv = 1'b0;
      lb = 8'd0;
      if (fill_cnt < FIFO_CAP && mode_q[MODE_ENABLED]) begin
         rx_mem[wr_idx] = ch;
         wr_idx = next_slot(wr_idx);
         fill_cnt++;
         echo = mode_q[MODE_ECHO_ALL] || (mode_q[MODE_ECHO_TAB] && ch == BYTE_TAB)
            || (mode_q[MODE_ECHO_RET] && (ch == BYTE_LF || ch == BYTE_CR));
         if (mode_q[MODE_INTR_ANY] || (mode_q[MODE_INTR_ESC] && ch == BYTE_ESC)
               || (mode_q[MODE_INTR_RET] && ch == BYTE_LF)
               || (thresh_q != 8'd0 && fill_cnt >= int'(thresh_q)))
            done_q = 1'b1;
         if (echo) begin
            lv = 1'b1;
            lb = ch;
         end
      end else begin
         lv = 1'b1;
         lb = BYTE_BELL;
      end
   endtask

   task automatic predict_term(input logic [1:0] kind, input logic [7:0] lb,
         input logic [3:0] tr, input logic [1:0] ctl, input logic [23:0] data);
      term_out_type r;
      r = '0;
      case (kind)
         KIND_LINE: begin
            case (filt_q)
               FILT_CMD: begin
                  if (lb == BYTE_IAC) begin
                     push_rx(lb, r.line_valid, r.line_byte);
                     filt_q = FILT_DATA;
                  end else if (lb == BYTE_SB) begin
                     filt_q = FILT_SUBNEG;
                  end else if (lb < BYTE_CMD_LOW) begin
                     filt_q = FILT_DATA;
                  end
               end
               FILT_SUBNEG: begin
                  if (lb == BYTE_SE)
                     filt_q = FILT_DATA;
               end
               default: begin
                  filt_q = FILT_DATA;
                  if (lb == BYTE_IAC)
                     filt_q = FILT_CMD;
                  else
                     push_rx(lb, r.line_valid, r.line_byte);
               end
            endcase
         end
         KIND_BUS: begin
            if (tr == XFER_TX) begin
               tx_q = data[7:0];
            end else if (tr == XFER_MODE) begin
               mode_q = data[23:8];
               thresh_q = data[7:0];
            end
            if (tr != XFER_STATUS) begin
               if (ctl == CTL_START) begin
                  tx_pend_q = 1'b1;
                  done_q = 1'b0;
               end else if (ctl == CTL_STOP) begin
                  tx_pend_q = 1'b0;
                  done_q = 1'b0;
               end
            end
            if (tr == XFER_STATUS) begin
               r.read_data = {7'd0, done_q, tx_pend_q};
            end else if (tr == XFER_POP) begin
               if (fill_cnt == 0) begin
                  r.read_data = READ_EMPTY;
               end else begin
                  r.read_data = {1'b0, rx_mem[rd_idx]};
                  rd_idx = next_slot(rd_idx);
                  fill_cnt--;
               end
            end
         end
         KIND_TICK: begin
            if (tx_pend_q) begin
               r.line_valid = 1'b1;
               r.line_byte = tx_q;
               tx_pend_q = 1'b0;
            end
         end
         default: begin
         end
      endcase
      r.irq = done_q;
      term_out_q.push_back(r);
   endtask

   task automatic check_field(input string field, input logic signed [31:0] want,
         input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      term_out_type want;
      if (reset) begin
         filt_q = FILT_DATA;
         rd_idx = 0;
         wr_idx = 0;
         fill_cnt = 0;
         mode_q = MODE_RESET;
         thresh_q = 8'd0;
         tx_q = 8'd0;
         tx_pend_q = 1'b0;
         done_q = 1'b0;
         term_out_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_term(req_kind, req_line_byte, req_transfer_code, req_control_code,
               req_bus_data);
         if (rsp_valid && !rsp_stall) begin
            if (term_out_q.size() == 0) begin
               $display("%0t ns: result transfer with no prediction pending", $time);
               fail_count++;
            end else begin
               want = term_out_q.pop_front();
               check_field("line_out_valid", {31'd0, want.line_valid},
                  {31'd0, rsp_line_out_valid});
               check_field("line_out_byte", {24'd0, want.line_byte},
                  {24'd0, rsp_line_out_byte});
               check_field("read_data", 32'($signed(want.read_data)),
                  32'($signed(rsp_read_data)));
               check_field("irq_level", {31'd0, want.irq}, {31'd0, rsp_irq_level});
            end
         end
      end
      pending_count = term_out_q.size();
   end

endmodule

/* sim/tb_telnet_terminal_receive_fifo_device_top.sv */
`timescale 1ns / 100ps
// Testbench top for the telnet terminal receive FIFO device: clock, reset, stimulus
// with random idling on both channels, and the final verdict.
// Depends on tfd_pkg, tfd_result_monitor and telnet_terminal_receive_fifo_device_top.
module tb_telnet_terminal_receive_fifo_device_top;
   import tfd_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] CTL_NONE    = 2'd0;
   localparam int         RANDOM_ITEMS = 1800;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = 2'd0;
   logic [7:0]         req_line_byte = 8'd0;
   logic [3:0]         req_transfer_code = 4'd0;
   logic [1:0]         req_control_code = 2'd0;
   logic [23:0]        req_bus_data = 24'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_line_out_valid;
   logic [7:0]         rsp_line_out_byte;
   logic signed [8:0]  rsp_read_data;
   logic               rsp_irq_level;
   int                 fail_count;
   int                 pending_count;

   logic calm = 1'b0;
   int   stall_left = 0;
   int   line_items = 0;
   int   bus_items = 0;
   int   tick_items = 0;
   int   odd_items = 0;
   int   phase_total = 0;
   int   fill_phases = 0;

   telnet_terminal_receive_fifo_device_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_line_byte      (req_line_byte),
      .req_transfer_code  (req_transfer_code),
      .req_control_code   (req_control_code),
      .req_bus_data       (req_bus_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_out_valid (rsp_line_out_valid),
      .rsp_line_out_byte  (rsp_line_out_byte),
      .rsp_read_data      (rsp_read_data),
      .rsp_irq_level      (rsp_irq_level)
   );

   tfd_result_monitor u_monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_line_byte      (req_line_byte),
      .req_transfer_code  (req_transfer_code),
      .req_control_code   (req_control_code),
      .req_bus_data       (req_bus_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_out_valid (rsp_line_out_valid),
      .rsp_line_out_byte  (rsp_line_out_byte),
      .rsp_read_data      (rsp_read_data),
      .rsp_irq_level      (rsp_irq_level),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver draws a fresh stall length after every result transfer.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         stall_left = calm ? 0 : $urandom_range(0, 16);
      else if (stall_left > 0)
         stall_left--;
      rsp_stall <= (stall_left > 0);
   end

   function automatic int items_sent();
      return line_items + bus_items + tick_items + odd_items;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [7:0] lb,
         input logic [3:0] tr, input logic [1:0] ctl, input logic [23:0] data);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_line_byte <= lb;
      req_transfer_code <= tr;
      req_control_code <= ctl;
      req_bus_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (kind)
         KIND_LINE: line_items++;
         KIND_BUS:  bus_items++;
         KIND_TICK: tick_items++;
         default:   odd_items++;
      endcase
   endtask

   task automatic send_line(input logic [7:0] lb);
      send_item(KIND_LINE, lb, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
         24'($urandom));
   endtask

   task automatic send_bus(input logic [3:0] tr, input logic [1:0] ctl, input logic [23:0] data);
      send_item(KIND_BUS, 8'($urandom_range(0, 255)), tr, ctl, data);
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
         2'($urandom_range(0, 3)), 24'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic [1:0] pick_ctl();
      return ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : CTL_NONE;
   endfunction

   function automatic logic [23:0] mode_word(input logic force_on);
      logic [15:0] m;
      logic [7:0]  th;
      m = 16'($urandom);
      if (force_on || $urandom_range(0, 9) != 0)
         m[MODE_ENABLED] = 1'b1;
      th = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      return {m, th};
   endfunction

   function automatic logic [7:0] pick_line_byte();
      case ($urandom_range(0, 9))
         0: return BYTE_ESC;
         1: return BYTE_LF;
         2: return BYTE_CR;
         3: return BYTE_TAB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_telnet_seq();
      int n;
      case ($urandom_range(0, 3))
         0: begin
            send_line(BYTE_IAC);
            send_line(BYTE_IAC);
         end
         1: begin
            send_line(BYTE_IAC);
            send_line(8'($urandom_range(0, 249)));
         end
         2: begin
            send_line(BYTE_IAC);
            send_line(8'($urandom_range(251, 254)));
            send_line(8'($urandom_range(0, 255)));
         end
         default: begin
            n = $urandom_range(0, 6);
            send_line(BYTE_IAC);
            send_line(BYTE_SB);
            repeat (n) send_line(8'($urandom_range(0, 255)));
            send_line(BYTE_SE);
         end
      endcase
   endtask

   task automatic send_random_item(input int pop_pct, input logic filling);
      int r;
      if ($urandom_range(0, 99) < pop_pct) begin
         send_bus(XFER_POP, pick_ctl(), 24'($urandom));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70 || (filling && r >= 93 && r < 96))
            send_line(pick_line_byte());
         else if (r < 78)
            send_telnet_seq();
         else if (r < 84)
            send_tick();
         else if (r < 87)
            send_bus(XFER_TX, CTL_START, 24'($urandom));
         else if (r < 90)
            send_bus(XFER_STATUS, 2'($urandom_range(0, 3)), 24'($urandom));
         else if (r < 93)
            send_bus(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), 24'($urandom));
         else if (r < 96)
            send_bus(XFER_MODE, pick_ctl(), mode_word(1'b0));
         else if (r < 97)
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               2'($urandom_range(0, 3)), 24'($urandom));
         else
            send_bus(4'($urandom_range(0, 15)), CTL_STOP, 24'($urandom));
      end
   endtask

   initial begin
      int phase_len;
      int pop_pct;
      logic filling;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_bus(XFER_POP, CTL_NONE, 24'h000000);
      send_bus(XFER_STATUS, CTL_START, 24'hFFFFFF);
      send_line(8'h41);
      send_bus(XFER_MODE, CTL_NONE, {16'h01C9, 8'd0});
      send_line(8'h00);
      send_line(BYTE_IAC);
      send_line(BYTE_IAC);
      send_line(BYTE_IAC);
      send_line(8'd251);
      send_line(8'd3);
      send_line(BYTE_IAC);
      send_line(BYTE_SB);
      send_line(8'h18);
      send_line(BYTE_SE);
      send_bus(XFER_MODE, CTL_NONE, {16'h0085, 8'd0});
      send_line(BYTE_TAB);
      send_line(BYTE_ESC);
      send_bus(XFER_TX, CTL_START, 24'h00005A);
      send_tick();
      send_tick();
      send_bus(XFER_MODE, CTL_STOP, {16'h0049, 8'd6});
      send_line(BYTE_LF);
      send_bus(XFER_POP, CTL_STOP, 24'h000000);
      send_line(BYTE_CR);
      send_line(8'h80);
      send_item(KIND_UNUSED, 8'hFF, 4'hF, 2'd3, 24'hFFFFFF);
      send_bus(4'd7, CTL_START, 24'hFFFFFF);
      send_bus(XFER_STATUS, CTL_NONE, 24'h000000);
      wait_drained();

      while (items_sent() < RANDOM_ITEMS + 28) begin
         filling = (phase_total == 0) || ($urandom_range(0, 3) == 0);
         calm <= ($urandom_range(0, 3) == 0);
         if (filling) begin
            phase_len = 500;
            pop_pct = 1;
            fill_phases++;
         end else begin
            phase_len = $urandom_range(80, 300);
            pop_pct = ($urandom_range(0, 1) == 0) ? 50 : 20;
         end
         send_bus(XFER_MODE, CTL_NONE, mode_word(filling));
         for (int i = 0; i < phase_len && items_sent() < RANDOM_ITEMS + 28; i++)
            send_random_item(pop_pct, filling);
         if ($urandom_range(0, 2) == 0)
            wait_drained();
         phase_total++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Run covered %0d line bytes, %0d bus accesses, %0d transmitter ticks and %0d items of the unused kind.",
         line_items, bus_items, tick_items, odd_items);
      $display("It went through %0d random phases, %0d of them filling the receive FIFO.",
         phase_total, fill_phases);
      if (fail_count == 0)
         $display("tb_telnet_terminal_receive_fifo_device_top passed");
      else
         $display("tb_telnet_terminal_receive_fifo_device_top failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_telnet_terminal_receive_fifo_device_top failed");
      $finish;
   end

endmodule
